// ===== design/wtm_pkg.sv =====
package wtm_pkg;

   // pattern store size and derived widths
   localparam int PATTERN_MAX = 64;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int CHAR_W      = 8;

   // wildcard characters
   localparam logic [CHAR_W-1:0] STAR_CODE  = 8'h2A;
   localparam logic [CHAR_W-1:0] QMARK_CODE = 8'h3F;

   // request operation codes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TEXT  = 2'd1,
      OP_EMPTY = 2'd2
   } op_type;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic              load_valid;
      logic [LEN_W-1:0]  load_index;
      logic              text_valid;
      logic              text_start;
      logic [CHAR_W-1:0] char_code;
      logic [LEN_W-1:0]  length;
   } cell_ctl_type;

endpackage

// ===== design/wtm_cell.sv =====
module wtm_cell
   import wtm_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [LEN_W-1:0] cell_index,
   input  logic             prev_prefix,
   input  logic             prev_row,
   input  logic             prev_next,
   output logic             prefix_out,
   output logic             row_out,
   output logic             next_out,
   output logic             hit
);

   logic [CHAR_W-1:0] char_ff;
   logic              prefix_ff;
   logic              row_ff;
   logic              cell_valid;
   logic              is_star;
   logic              single_match;

   // stored pattern character and all-star prefix flag
   always_ff @(posedge clock) begin
      if (ctl.load_valid && (ctl.load_index == cell_index)) begin
         char_ff   <= ctl.char_code;
         prefix_ff <= prev_prefix && (ctl.char_code == STAR_CODE);
      end
   end

   assign cell_valid   = cell_index < ctl.length;
   assign is_star      = char_ff == STAR_CODE;
   assign single_match = (char_ff == QMARK_CODE) || (char_ff == ctl.char_code);

   // current row bit, taken from the start row on the first text character
   assign row_out    = ctl.text_start ? prefix_ff : row_ff;
   assign prefix_out = prefix_ff;

   // row update, star cells ripple from the left neighbor
   always_comb begin
      next_out = 1'b0;
      if (cell_valid) begin
         if (is_star) begin
            next_out = row_out || prev_next;
         end else if (single_match) begin
            next_out = prev_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.text_valid) begin
         row_ff <= next_out;
      end
   end

   // this cell holds the final pattern character
   assign hit = next_out && ((cell_index + LEN_W'(1)) == ctl.length);

endmodule

// ===== design/wtm_row.sv =====
module wtm_row
   import wtm_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   output logic         hit
);

   logic [PATTERN_MAX:0]   prefix_c;
   logic [PATTERN_MAX:0]   row_c;
   logic [PATTERN_MAX:0]   next_c;
   logic [PATTERN_MAX-1:0] hit_c;

   // left edge: empty prefix always matches at text start
   assign prefix_c[0] = 1'b1;
   assign row_c[0]    = ctl.text_start;
   assign next_c[0]   = 1'b0;

   // chain of cells, one per pattern position
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      wtm_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_index  (LEN_W'(i)),
         .prev_prefix (prefix_c[i]),
         .prev_row    (row_c[i]),
         .prev_next   (next_c[i]),
         .prefix_out  (prefix_c[i+1]),
         .row_out     (row_c[i+1]),
         .next_out    (next_c[i+1]),
         .hit         (hit_c[i])
      );
   end

   assign hit = |hit_c;

endmodule

// ===== design/wildcard_text_matcher_top.sv =====
// wildcard text matcher
// One request channel (req_) and one response channel (rsp_), both valid/ready.
// A request is a pattern character load, a text character or an empty text
// query. Pattern characters are stored in a row of 64 cells; '?' matches any
// one character and '*' any run. Text characters then stream through, and each
// cell updates its match bit, with star cells rippling from left to right in
// the same cycle. Only the last text character and the empty query give a
// response: matched plus pattern_error (pattern longer than 64 characters).
// Throughput: one request per cycle while the response is not stalled. A
// response is valid the cycle after its request is accepted, held in one
// output register. When the receiver stalls, the response waits in the output
// register and req_ready drops until it is taken; a request accepted in the
// cycle the response drains keeps the rate at one per cycle.
// Reset (synchronous, active high) empties the pattern, clears the overflow
// flag, closes any open text and drops rsp_valid.
module wildcard_text_matcher_top
   import wtm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_matched,
   output logic              rsp_pattern_error
);

   logic [LEN_W-1:0] length_ff, length_in;
   logic             overflow_ff, overflow_in;
   logic             restart_ff, restart_in;
   logic             text_open_ff, text_open_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             error_ff, error_in;

   logic             accept;
   logic [LEN_W-1:0] base_len;
   logic             base_ovf;
   logic             full;
   logic             hit;
   cell_ctl_type     ctl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // where the next pattern character goes
   assign base_len = restart_ff ? '0 : length_ff;
   assign base_ovf = restart_ff ? 1'b0 : overflow_ff;
   assign full     = base_len == LEN_W'(PATTERN_MAX);

   // cell controls
   always_comb begin
      ctl            = '0;
      ctl.load_valid = accept && (req_operation == OP_LOAD) && !full;
      ctl.load_index = base_len;
      ctl.text_valid = accept && (req_operation == OP_TEXT);
      ctl.text_start = !text_open_ff;
      ctl.char_code  = req_char_code;
      ctl.length     = length_ff;
   end

   wtm_row u_row (
      .clock (clock),
      .ctl   (ctl),
      .hit   (hit)
   );

   // request sequencing and response capture
   always_comb begin
      length_in    = length_ff;
      overflow_in  = overflow_ff;
      restart_in   = restart_ff;
      text_open_in = text_open_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      matched_in   = matched_ff;
      error_in     = error_ff;
      if (accept) begin
         unique case (req_operation)
            OP_LOAD: begin
               length_in    = full ? base_len : base_len + LEN_W'(1);
               overflow_in  = base_ovf || full;
               restart_in   = req_last;
               text_open_in = 1'b0;
            end
            OP_TEXT: begin
               text_open_in = !req_last;
               if (req_last) begin
                  rsp_valid_in = 1'b1;
                  matched_in   = hit && !overflow_ff;
                  error_in     = overflow_ff;
               end
            end
            OP_EMPTY: begin
               text_open_in = 1'b0;
               rsp_valid_in = 1'b1;
               matched_in   = 1'b0;
               error_in     = overflow_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         overflow_ff  <= 1'b0;
         restart_ff   <= 1'b1;
         text_open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         overflow_ff  <= overflow_in;
         restart_ff   <= restart_in;
         text_open_ff <= text_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      error_ff   <= error_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = matched_ff;
   assign rsp_pattern_error = error_ff;

endmodule

// ===== design/wtm_checker.sv =====
module wtm_checker
   import wtm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_operation,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_matched,
   input logic              rsp_pattern_error
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched)
         && $stable(rsp_pattern_error))
      else $error("stalled response changed");

   // an overflowed pattern never matches
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_error |-> !rsp_matched)
      else $error("match reported with pattern error");

   // empty query answers no match in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_EMPTY)
         |=> rsp_valid && !rsp_matched)
      else $error("empty query response missing or matched");

   // pattern loads give no response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_LOAD) |=> !rsp_valid)
      else $error("response after pattern load");

   // inner text characters give no response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_TEXT) && !req_last
         |=> !rsp_valid)
      else $error("response before last text character");

endmodule

bind wildcard_text_matcher_top wtm_checker u_wtm_checker (.*);
